/* rtl/gdr_pkg.sv */
`default_nettype none
package gdr_pkg;

   localparam int MAP_DIM_DEF   = 64;
   localparam int FRAC_BITS_DEF = 16;
   localparam int POS_W   = 22;
   localparam int DIR_W   = 19;
   localparam int CELL_W  = 6;
   localparam int PERP_W  = 24;
   localparam int LH_W    = 16;
   localparam int SCR_W   = 12;
   localparam int DIV_W   = 64;
   localparam int DIVC_W  = 7;

   localparam logic [SCR_W-1:0] SCREEN_HEIGHT_RESET = 12'd480;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_CAST  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_DIV_DDX,
      ST_DIV_SDX,
      ST_DIV_DDY,
      ST_DIV_SDY,
      ST_STEP,
      ST_READ,
      ST_TEST,
      ST_DIV_PERP,
      ST_DIV_LH,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic              start;
      logic [DIV_W-1:0]  dividend;
      logic [DIV_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DIV_W-1:0]  quotient;
   } div_rsp_type;

endpackage
`default_nettype wire

/* rtl/gdr_ram.sv */
`default_nettype none
module gdr_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

/* rtl/gdr_div.sv */
`default_nettype none
module gdr_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire gdr_pkg::div_req_type req,
   output gdr_pkg::div_rsp_type      rsp
);

   localparam int W = gdr_pkg::DIV_W;

   logic [W-1:0]              quo_ff, quo_in;
   logic [W:0]                rem_ff, rem_in;
   logic [W-1:0]              den_ff, den_in;
   logic [gdr_pkg::DIVC_W-1:0] cnt_ff, cnt_in;
   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [W:0]                trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
   end

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[W-1:0], quo_ff[W-1]};
      if (req.start && !busy_ff) begin
         quo_in  = req.dividend;
         rem_in  = '0;
         den_in  = req.divisor;
         cnt_in  = gdr_pkg::DIVC_W'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == gdr_pkg::DIVC_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule
`default_nettype wire

/* rtl/grid_dda_raycaster.sv */
// channel   ports                                   direction
// req       start busy req_* fields                 in, busy back
// rsp       rsp_strobe rsp_* fields                 out, one cycle
// csr       csr_valid csr_ready csr_screen_height   in
// a write is taken in its accept cycle and busy stays low
// a cast runs up to six divisions on the shared divider (four setup, distance,
// height) and walks up to 2*MAP_DIM+4 grid cells through the step, read and test
// states, then the finish state; rsp_strobe comes in the cycle after finish
// after reset a clearing pass over all 4096 grid cells (default grid) holds busy high
// rsp_strobe lasts one cycle, the receiver cannot stall
`default_nettype none
module grid_dda_raycaster #(
   parameter int MAP_DIM   = gdr_pkg::MAP_DIM_DEF,
   parameter int FRAC_BITS = gdr_pkg::FRAC_BITS_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire logic                       req_opcode,
   input  wire logic [gdr_pkg::CELL_W-1:0] req_cell_x,
   input  wire logic [gdr_pkg::CELL_W-1:0] req_cell_y,
   input  wire logic                       req_cell_is_wall,
   input  wire logic [gdr_pkg::POS_W-1:0]  req_pos_x,
   input  wire logic [gdr_pkg::POS_W-1:0]  req_pos_y,
   input  wire logic signed [gdr_pkg::DIR_W-1:0] req_dir_x,
   input  wire logic signed [gdr_pkg::DIR_W-1:0] req_dir_y,
   output logic                            rsp_strobe,
   output logic                            rsp_hit_found,
   output logic                            rsp_hit_side,
   output logic [gdr_pkg::CELL_W-1:0]      rsp_hit_cell_x,
   output logic [gdr_pkg::CELL_W-1:0]      rsp_hit_cell_y,
   output logic [gdr_pkg::PERP_W-1:0]      rsp_perp_distance,
   output logic [gdr_pkg::LH_W-1:0]        rsp_line_height,
   output logic [gdr_pkg::SCR_W-1:0]       rsp_draw_start,
   output logic [gdr_pkg::SCR_W-1:0]       rsp_draw_end,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [gdr_pkg::SCR_W-1:0]  csr_screen_height
);

   localparam int MB    = $clog2(MAP_DIM);
   localparam int AB    = 2 * MB;
   localparam int DEPTH = 1 << AB;
   localparam int W     = gdr_pkg::DIV_W;
   localparam int CW    = MB + 2;
   localparam logic [W-1:0] ONE = W'(1) << FRAC_BITS;
   localparam logic [W-1:0] PERP_MAX = W'({gdr_pkg::PERP_W{1'b1}});
   localparam logic [W-1:0] LH_MAX   = W'({gdr_pkg::LH_W{1'b1}});
   localparam int KW = $clog2(2 * MAP_DIM + 5);

   gdr_pkg::state_type state_ff, state_in;
   logic [gdr_pkg::SCR_W-1:0] scr_ff;
   logic [AB-1:0]  clr_ff, clr_in;
   logic [gdr_pkg::POS_W-1:0] px_ff, px_in, py_ff, py_in;
   logic signed [gdr_pkg::DIR_W-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic signed [CW-1:0] mx_ff, mx_in, my_ff, my_in;
   logic [W-1:0] ddx_ff, ddx_in, ddy_ff, ddy_in, sdx_ff, sdx_in, sdy_ff, sdy_in;
   logic          side_ff, side_in;
   logic [KW-1:0] k_ff, k_in;
   logic [W-1:0]  perp_ff, perp_in;
   logic          rs_ff, rs_in, rh_ff, rh_in;
   logic [gdr_pkg::LH_W-1:0]  lh_ff, lh_in;
   logic [gdr_pkg::SCR_W-1:0] ds_ff, ds_in, de_ff, de_in;

   gdr_pkg::div_req_type dreq;
   gdr_pkg::div_rsp_type drsp;

   logic          wr_en;
   logic [AB-1:0] wr_addr, rd_addr;
   logic          wr_data, rd_data;

   logic [gdr_pkg::DIR_W-1:0] magx, magy;
   logic [W-1:0] fracx, fracy;
   logic [W-1:0] pnum;
   logic         pneg, pzero_d, pnum_zero, pbad;
   logic [gdr_pkg::DIR_W-1:0] pden;
   logic [W-1:0] lhq;
   logic [gdr_pkg::LH_W-1:0] lhs;
   logic [gdr_pkg::SCR_W-1:0] half_h;
   logic signed [W-1:0] pos_s, cell_s;
   logic cmx, oob;

   gdr_div u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   gdr_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_grid (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   assign csr_ready = (state_ff == gdr_pkg::ST_IDLE) && !start;
   assign busy      = (state_ff != gdr_pkg::ST_IDLE);
   assign rd_addr   = {mx_ff[MB-1:0], my_ff[MB-1:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= gdr_pkg::ST_CLEAR;
         scr_ff     <= gdr_pkg::SCREEN_HEIGHT_RESET;
         clr_ff     <= '0;
         rsp_strobe <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         if (csr_valid && csr_ready) begin
            scr_ff <= csr_screen_height;
         end
         rsp_strobe <= (state_ff == gdr_pkg::ST_FINISH);
      end
      px_ff <= px_in;  py_ff <= py_in;
      dx_ff <= dx_in;  dy_ff <= dy_in;
      mx_ff <= mx_in;  my_ff <= my_in;
      ddx_ff <= ddx_in; ddy_ff <= ddy_in;
      sdx_ff <= sdx_in; sdy_ff <= sdy_in;
      side_ff <= side_in; k_ff <= k_in;
      perp_ff <= perp_in; rs_ff <= rs_in; rh_ff <= rh_in;
      lh_ff <= lh_in; ds_ff <= ds_in; de_ff <= de_in;
   end

   assign rsp_hit_found     = rh_ff;
   assign rsp_hit_side      = rs_ff;
   assign rsp_hit_cell_x    = gdr_pkg::CELL_W'(mx_ff[MB-1:0]) & {gdr_pkg::CELL_W{rh_ff}};
   assign rsp_hit_cell_y    = gdr_pkg::CELL_W'(my_ff[MB-1:0]) & {gdr_pkg::CELL_W{rh_ff}};
   assign rsp_perp_distance = perp_ff[gdr_pkg::PERP_W-1:0];
   assign rsp_line_height   = lh_ff;
   assign rsp_draw_start    = ds_ff;
   assign rsp_draw_end      = de_ff;

   always_comb begin
      magx  = dx_ff[gdr_pkg::DIR_W-1] ? gdr_pkg::DIR_W'(-dx_ff) : dx_ff;
      magy  = dy_ff[gdr_pkg::DIR_W-1] ? gdr_pkg::DIR_W'(-dy_ff) : dy_ff;
      fracx = dx_ff[gdr_pkg::DIR_W-1] ? W'(px_ff[FRAC_BITS-1:0])
            : ONE - W'(px_ff[FRAC_BITS-1:0]);
      fracy = dy_ff[gdr_pkg::DIR_W-1] ? W'(py_ff[FRAC_BITS-1:0])
            : ONE - W'(py_ff[FRAC_BITS-1:0]);
      cmx    = (side_ff == 1'b0);
      pos_s  = cmx ? W'(px_ff) : W'(py_ff);
      cell_s = (cmx ? W'(signed'(mx_ff)) : W'(signed'(my_ff))) << FRAC_BITS;
      cell_s = cell_s - pos_s +
               ((cmx ? dx_ff[gdr_pkg::DIR_W-1] : dy_ff[gdr_pkg::DIR_W-1]) ? ONE : '0);
      pden   = cmx ? magx : magy;
      pneg   = cell_s[W-1];
      pnum   = pneg ? W'(-cell_s) : cell_s;
      pnum_zero = (cell_s == '0);
      pzero_d   = (pden == '0);
      pbad      = pneg != (cmx ? dx_ff[gdr_pkg::DIR_W-1] : dy_ff[gdr_pkg::DIR_W-1]);
      lhq    = (drsp.quotient > LH_MAX) ? LH_MAX : drsp.quotient;
      lhs    = (perp_ff == '0) ? gdr_pkg::LH_W'(LH_MAX) : gdr_pkg::LH_W'(lhq);
      half_h = scr_ff >> 1;
      oob    = mx_ff < 0 || my_ff < 0 || mx_ff >= CW'(MAP_DIM) || my_ff >= CW'(MAP_DIM);
   end

   logic [gdr_pkg::LH_W:0] lh2w, endw;
   logic [gdr_pkg::LH_W:0] startw;
   always_comb begin
      lh2w   = {2'b00, lh_ff[gdr_pkg::LH_W-1:1]};
      startw = ({5'b0, half_h} > lh2w) ? ({5'b0, half_h} - lh2w) : '0;
      endw   = lh2w + {5'b0, half_h};
      if (endw >= {5'b0, scr_ff}) begin
         endw = (scr_ff == '0) ? '0 : {5'b0, scr_ff} - 1'b1;
      end
   end

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      px_in = px_ff; py_in = py_ff; dx_in = dx_ff; dy_in = dy_ff;
      mx_in = mx_ff; my_in = my_ff;
      ddx_in = ddx_ff; ddy_in = ddy_ff; sdx_in = sdx_ff; sdy_in = sdy_ff;
      side_in = side_ff; k_in = k_ff; perp_in = perp_ff;
      rs_in = rs_ff; rh_in = rh_ff; lh_in = lh_ff; ds_in = ds_ff; de_in = de_ff;
      dreq.start = 1'b0; dreq.dividend = '0; dreq.divisor = '0;
      wr_en = 1'b0; wr_addr = clr_ff; wr_data = 1'b0;
      unique case (state_ff)
         gdr_pkg::ST_CLEAR: begin
            wr_en  = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AB'(DEPTH - 1)) state_in = gdr_pkg::ST_IDLE;
         end
         gdr_pkg::ST_IDLE: begin
            if (start) begin
               px_in = req_pos_x; py_in = req_pos_y;
               dx_in = req_dir_x; dy_in = req_dir_y;
               mx_in = CW'(req_pos_x >> FRAC_BITS);
               my_in = CW'(req_pos_y >> FRAC_BITS);
               rh_in = 1'b0; rs_in = 1'b0; perp_in = '0; lh_in = '0;
               ds_in = '0; de_in = '0; side_in = 1'b0; k_in = '0;
               if (req_opcode == gdr_pkg::OP_WRITE) begin
                  wr_addr = {req_cell_x[MB-1:0], req_cell_y[MB-1:0]};
                  wr_data = req_cell_is_wall;
                  wr_en   = (32'(req_cell_x) < MAP_DIM) && (32'(req_cell_y) < MAP_DIM);
               end else if ((req_pos_x >> FRAC_BITS) >= MAP_DIM ||
                            (req_pos_y >> FRAC_BITS) >= MAP_DIM) begin
                  state_in = gdr_pkg::ST_FINISH;
               end else begin
                  state_in = gdr_pkg::ST_DIV_DDX;
               end
            end
         end
         gdr_pkg::ST_DIV_DDX: begin
            state_in = gdr_pkg::ST_DIV_SDX;
            if (dy_ff == '0) begin
               ddx_in = '0;
            end else if (dx_ff == '0) begin
               ddx_in = ONE;
            end else begin
               dreq = '{1'b1, W'(1) << (2 * FRAC_BITS), W'(magx)};
               state_in = gdr_pkg::ST_DIV_DDX;
               if (drsp.done) begin
                  ddx_in = drsp.quotient; state_in = gdr_pkg::ST_DIV_SDX;
                  dreq.start = 1'b0;
               end
            end
         end
         gdr_pkg::ST_DIV_SDX: begin
            state_in = gdr_pkg::ST_DIV_DDY;
            if (dy_ff == '0) begin
               sdx_in = '0;
            end else if (dx_ff == '0) begin
               sdx_in = fracx;
            end else begin
               dreq = '{1'b1, fracx << FRAC_BITS, W'(magx)};
               state_in = gdr_pkg::ST_DIV_SDX;
               if (drsp.done) begin
                  sdx_in = drsp.quotient; state_in = gdr_pkg::ST_DIV_DDY;
                  dreq.start = 1'b0;
               end
            end
         end
         gdr_pkg::ST_DIV_DDY: begin
            state_in = gdr_pkg::ST_DIV_SDY;
            if (dx_ff == '0) begin
               ddy_in = '0;
            end else if (dy_ff == '0) begin
               ddy_in = ONE;
            end else begin
               dreq = '{1'b1, W'(1) << (2 * FRAC_BITS), W'(magy)};
               state_in = gdr_pkg::ST_DIV_DDY;
               if (drsp.done) begin
                  ddy_in = drsp.quotient; state_in = gdr_pkg::ST_DIV_SDY;
                  dreq.start = 1'b0;
               end
            end
         end
         gdr_pkg::ST_DIV_SDY: begin
            state_in = gdr_pkg::ST_STEP;
            if (dx_ff == '0) begin
               sdy_in = '0;
            end else if (dy_ff == '0) begin
               sdy_in = fracy;
            end else begin
               dreq = '{1'b1, fracy << FRAC_BITS, W'(magy)};
               state_in = gdr_pkg::ST_DIV_SDY;
               if (drsp.done) begin
                  sdy_in = drsp.quotient; state_in = gdr_pkg::ST_STEP;
                  dreq.start = 1'b0;
               end
            end
         end
         gdr_pkg::ST_STEP: begin
            if (k_ff == KW'(2 * MAP_DIM + 4)) begin
               state_in = gdr_pkg::ST_FINISH;
            end else begin
               k_in = k_ff + 1'b1;
               if (sdx_ff < sdy_ff) begin
                  sdx_in = sdx_ff + ddx_ff;
                  mx_in  = dx_ff[gdr_pkg::DIR_W-1] ? mx_ff - 1'b1 : mx_ff + 1'b1;
                  side_in = 1'b0;
               end else begin
                  sdy_in = sdy_ff + ddy_ff;
                  my_in  = dy_ff[gdr_pkg::DIR_W-1] ? my_ff - 1'b1 : my_ff + 1'b1;
                  side_in = 1'b1;
               end
               state_in = gdr_pkg::ST_READ;
            end
         end
         gdr_pkg::ST_READ: begin
            state_in = oob ? gdr_pkg::ST_FINISH : gdr_pkg::ST_TEST;
         end
         gdr_pkg::ST_TEST: begin
            if (rd_data) begin
               rh_in = 1'b1; rs_in = side_ff;
               if (pzero_d) begin
                  perp_in = PERP_MAX; state_in = gdr_pkg::ST_DIV_LH;
               end else if (pnum_zero || pbad) begin
                  perp_in = '0; state_in = gdr_pkg::ST_DIV_LH;
               end else begin
                  state_in = gdr_pkg::ST_DIV_PERP;
               end
            end else begin
               state_in = gdr_pkg::ST_STEP;
            end
         end
         gdr_pkg::ST_DIV_PERP: begin
            dreq = '{1'b1, pnum << FRAC_BITS, W'(pden)};
            if (drsp.done) begin
               dreq.start = 1'b0;
               perp_in = (drsp.quotient > PERP_MAX) ? PERP_MAX : drsp.quotient;
               state_in = gdr_pkg::ST_DIV_LH;
            end
         end
         gdr_pkg::ST_DIV_LH: begin
            if (perp_ff == '0) begin
               lh_in = lhs; state_in = gdr_pkg::ST_FINISH;
               rh_in = 1'b1;
            end else begin
               dreq = '{1'b1, W'(scr_ff) << FRAC_BITS, perp_ff};
               if (drsp.done) begin
                  dreq.start = 1'b0;
                  lh_in = lhs;
                  state_in = gdr_pkg::ST_FINISH;
               end
            end
         end
         gdr_pkg::ST_FINISH: begin
            if (!rh_ff) begin
               side_in = 1'b0; mx_in = '0; my_in = '0;
            end else begin
               ds_in = gdr_pkg::SCR_W'(startw);
               de_in = gdr_pkg::SCR_W'(endw);
            end
            state_in = gdr_pkg::ST_IDLE;
         end
         default: state_in = gdr_pkg::ST_IDLE;
      endcase
   end

`ifndef SYNTHESIS
   a_busy_no_csr: assert property (@(posedge clock) disable iff (reset)
      busy |-> !csr_ready) else $error("csr ready while busy");
   a_strobe_after_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == gdr_pkg::ST_FINISH))
      else $error("strobe without finish");
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("strobe held");
   a_nohit_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_hit_found) |-> (rsp_perp_distance == '0 && rsp_line_height == '0))
      else $error("no-hit fields nonzero");
`endif

endmodule
`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 100ps
module testbench;

   localparam int DIM = gdr_pkg::MAP_DIM_DEF;
   localparam int ONE = 1 << 16;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct {
      logic                                 opcode;
      logic [gdr_pkg::CELL_W-1:0]           cell_x;
      logic [gdr_pkg::CELL_W-1:0]           cell_y;
      logic                                 is_wall;
      logic [gdr_pkg::POS_W-1:0]            pos_x;
      logic [gdr_pkg::POS_W-1:0]            pos_y;
      logic signed [gdr_pkg::DIR_W-1:0]     dir_x;
      logic signed [gdr_pkg::DIR_W-1:0]     dir_y;
   } ray_cmd_type;

   typedef struct packed {
      logic                       hit_found;
      logic                       hit_side;
      logic [gdr_pkg::CELL_W-1:0] cell_x;
      logic [gdr_pkg::CELL_W-1:0] cell_y;
      logic [gdr_pkg::PERP_W-1:0] perp;
      logic [gdr_pkg::LH_W-1:0]   line_height;
      logic [gdr_pkg::SCR_W-1:0]  first_row;
      logic [gdr_pkg::SCR_W-1:0]  last_row;
   } ray_hit_type;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic req_opcode = 0;
   logic [gdr_pkg::CELL_W-1:0] req_cell_x = 0, req_cell_y = 0;
   logic req_cell_is_wall = 0;
   logic [gdr_pkg::POS_W-1:0] req_pos_x = 0, req_pos_y = 0;
   logic signed [gdr_pkg::DIR_W-1:0] req_dir_x = 0, req_dir_y = 0;
   logic rsp_strobe, rsp_hit_found, rsp_hit_side;
   logic [gdr_pkg::CELL_W-1:0] rsp_hit_cell_x, rsp_hit_cell_y;
   logic [gdr_pkg::PERP_W-1:0] rsp_perp_distance;
   logic [gdr_pkg::LH_W-1:0] rsp_line_height;
   logic [gdr_pkg::SCR_W-1:0] rsp_draw_start, rsp_draw_end;
   logic csr_valid = 0;
   logic csr_ready;
   logic [gdr_pkg::SCR_W-1:0] csr_screen_height = 0;

   ray_cmd_type cmd_queue[$];
   ray_hit_type hit_queue[$];
   ray_cmd_type cur_cmd;
   bit wall_map[DIM][DIM];
   logic [gdr_pkg::SCR_W-1:0] screen_rows = gdr_pkg::SCREEN_HEIGHT_RESET;
   bit no_idle = 0;
   int errors = 0;
   int casts = 0, hits = 0, writes = 0, results = 0;
   int quiet_cycles = 0;

   always #4 clock = ~clock;

   grid_dda_raycaster dut (
      .clock, .reset, .start, .busy,
      .req_opcode, .req_cell_x, .req_cell_y, .req_cell_is_wall,
      .req_pos_x, .req_pos_y, .req_dir_x, .req_dir_y,
      .rsp_strobe, .rsp_hit_found, .rsp_hit_side, .rsp_hit_cell_x, .rsp_hit_cell_y,
      .rsp_perp_distance, .rsp_line_height, .rsp_draw_start, .rsp_draw_end,
      .csr_valid, .csr_ready, .csr_screen_height
   );

   function automatic void axis_init(input longint d, input longint o, input longint p,
                                     input longint c, output longint unsigned dd,
                                     output longint unsigned sd, output longint stp);
      longint unsigned mag;
      longint frac;
      mag = 64'((d < 0) ? -d : d);
      if (d < 0) begin
         stp = -1;
         frac = p - c * ONE;
      end else begin
         stp = 1;
         frac = (c + 1) * ONE - p;
      end
      if (o == 0) begin
         dd = 0;
         sd = 0;
      end else if (d == 0) begin
         dd = 64'(ONE);
         sd = 64'(frac);
      end else begin
         dd = (64'd1 << 32) / mag;
         sd = 64'(frac << 16) / mag;
      end
   endfunction

   function automatic longint unsigned perp_calc(input longint num, input longint d);
      longint unsigned an, ad, q;
      if (d == 0) return 64'hFFFFFF;
      if (num == 0) return 0;
      if ((num < 0) != (d < 0)) return 0;
      an = 64'((num < 0) ? -num : num);
      ad = 64'((d < 0) ? -d : d);
      q = (an << 16) / ad;
      return (q > 64'hFFFFFF) ? 64'hFFFFFF : q;
   endfunction

   function automatic ray_hit_type trace_ray(input ray_cmd_type c);
      ray_hit_type r;
      longint px, py, dx, dy, mx, my, stx, sty, h, lh2, st, en;
      longint unsigned ddx, ddy, sdx, sdy, perp, lh;
      bit side, hit;
      r = '0;
      side = 0;
      hit = 0;
      px = longint'(c.pos_x);
      py = longint'(c.pos_y);
      dx = longint'(c.dir_x);
      dy = longint'(c.dir_y);
      mx = px >>> 16;
      my = py >>> 16;
      if (mx >= DIM || my >= DIM) return r;
      axis_init(dx, dy, px, mx, ddx, sdx, stx);
      axis_init(dy, dx, py, my, ddy, sdy, sty);
      for (int k = 0; k < 2 * DIM + 4; k++) begin
         if (sdx < sdy) begin
            sdx += ddx;
            mx += stx;
            side = 0;
         end else begin
            sdy += ddy;
            my += sty;
            side = 1;
         end
         if (mx < 0 || mx >= DIM || my < 0 || my >= DIM) break;
         if (wall_map[mx][my]) begin
            hit = 1;
            break;
         end
      end
      if (!hit) return r;
      if (side == 0) perp = perp_calc(mx * ONE - px + ((stx < 0) ? ONE : 0), dx);
      else perp = perp_calc(my * ONE - py + ((sty < 0) ? ONE : 0), dy);
      h = longint'(screen_rows);
      if (perp == 0) lh = 64'hFFFF;
      else begin
         lh = 64'(h << 16) / perp;
         if (lh > 64'hFFFF) lh = 64'hFFFF;
      end
      lh2 = longint'(lh / 2);
      st = h / 2 - lh2;
      if (st < 0) st = 0;
      en = lh2 + h / 2;
      if (en >= h) en = h - 1;
      if (en < 0) en = 0;
      r.hit_found = 1;
      r.hit_side = side;
      r.cell_x = gdr_pkg::CELL_W'(mx);
      r.cell_y = gdr_pkg::CELL_W'(my);
      r.perp = gdr_pkg::PERP_W'(perp);
      r.line_height = gdr_pkg::LH_W'(lh);
      r.first_row = gdr_pkg::SCR_W'(st);
      r.last_row = gdr_pkg::SCR_W'(en);
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 0;
      end else if (start && busy) begin
         start <= start;
      end else begin
         if (start) begin
            if (cur_cmd.opcode == gdr_pkg::OP_WRITE) begin
               wall_map[cur_cmd.cell_x][cur_cmd.cell_y] = cur_cmd.is_wall;
               writes++;
            end else begin
               hit_queue.push_back(trace_ray(cur_cmd));
               casts++;
            end
         end
         if (cmd_queue.size() == 0 || (!no_idle && $urandom_range(99) < 14)) begin
            start <= 0;
         end else begin
            cur_cmd = cmd_queue.pop_front();
            start <= 1;
            req_opcode <= cur_cmd.opcode;
            req_cell_x <= cur_cmd.cell_x;
            req_cell_y <= cur_cmd.cell_y;
            req_cell_is_wall <= cur_cmd.is_wall;
            req_pos_x <= cur_cmd.pos_x;
            req_pos_y <= cur_cmd.pos_y;
            req_dir_x <= cur_cmd.dir_x;
            req_dir_y <= cur_cmd.dir_y;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      ray_hit_type got, want;
      if (!reset && rsp_strobe) begin
         got = {rsp_hit_found, rsp_hit_side, rsp_hit_cell_x, rsp_hit_cell_y,
                rsp_perp_distance, rsp_line_height, rsp_draw_start, rsp_draw_end};
         results++;
         if (got.hit_found) hits++;
         if (hit_queue.size() == 0) begin
            $display("%0t: unexpected transaction, actual %p", $time, got);
            errors++;
         end else begin
            want = hit_queue.pop_front();
            if (got !== want) begin
               $display("%0t: mismatch, expected %p actual %p", $time, want, got);
               errors++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe || (csr_valid && csr_ready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired", $time);
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic ray_cmd_type wall_cmd(input int x, input int y, input bit w);
      ray_cmd_type c;
      c = '{default: '0};
      c.opcode = gdr_pkg::OP_WRITE;
      c.cell_x = gdr_pkg::CELL_W'(x);
      c.cell_y = gdr_pkg::CELL_W'(y);
      c.is_wall = w;
      return c;
   endfunction

   function automatic ray_cmd_type cast_cmd(input int px, input int py, input int dx,
                                            input int dy);
      ray_cmd_type c;
      c = '{default: '0};
      c.opcode = gdr_pkg::OP_CAST;
      c.pos_x = gdr_pkg::POS_W'(px);
      c.pos_y = gdr_pkg::POS_W'(py);
      c.dir_x = gdr_pkg::DIR_W'(dx);
      c.dir_y = gdr_pkg::DIR_W'(dy);
      return c;
   endfunction

   function automatic logic signed [gdr_pkg::DIR_W-1:0] rand_dir();
      case ($urandom_range(9))
         0: return 0;
         1, 2, 3: return gdr_pkg::DIR_W'($urandom);
         default: return gdr_pkg::DIR_W'($signed($urandom_range(2 * ONE)) - ONE);
      endcase
   endfunction

   function automatic ray_cmd_type rand_cmd();
      ray_cmd_type c;
      if ($urandom_range(99) < 30) begin
         c = wall_cmd($urandom_range(DIM - 1), $urandom_range(DIM - 1),
                      $urandom_range(99) < 75);
         c.pos_x = gdr_pkg::POS_W'($urandom);
         c.pos_y = gdr_pkg::POS_W'($urandom);
         c.dir_x = gdr_pkg::DIR_W'($urandom);
         c.dir_y = gdr_pkg::DIR_W'($urandom);
      end else begin
         c = cast_cmd($urandom, $urandom, 0, 0);
         c.dir_x = rand_dir();
         c.dir_y = rand_dir();
         c.cell_x = gdr_pkg::CELL_W'($urandom);
         c.cell_y = gdr_pkg::CELL_W'($urandom);
         c.is_wall = 1'($urandom);
      end
      return c;
   endfunction

   task automatic drain();
      while (cmd_queue.size() != 0 || start || hit_queue.size() != 0) @(posedge clock);
      while (busy) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_rows(input logic [gdr_pkg::SCR_W-1:0] v);
      @(posedge clock);
      csr_valid <= 1;
      csr_screen_height <= v;
      do @(posedge clock); while (!csr_ready);
      screen_rows = v;
      csr_valid <= 0;
   endtask

   task automatic random_burst(input int n);
      repeat (n) cmd_queue.push_back(rand_cmd());
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 0;
      // corners, zero directions and extreme directions
      cmd_queue.push_back(wall_cmd(0, 0, 1));
      cmd_queue.push_back(wall_cmd(63, 63, 1));
      cmd_queue.push_back(wall_cmd(10, 5, 1));
      cmd_queue.push_back(wall_cmd(10, 6, 1));
      cmd_queue.push_back(wall_cmd(10, 6, 0));
      cmd_queue.push_back(wall_cmd(5, 20, 1));
      cmd_queue.push_back(cast_cmd(5 * ONE + ONE / 2, 5 * ONE + 100, ONE, 0));
      cmd_queue.push_back(cast_cmd(5 * ONE + 7, 5 * ONE, 0, 0));
      cmd_queue.push_back(cast_cmd(5 * ONE, 3 * ONE, 0, ONE));
      cmd_queue.push_back(cast_cmd(0, 0, -262144, -262144));
      cmd_queue.push_back(cast_cmd(4194303, 4194303, 262143, 262143));
      cmd_queue.push_back(cast_cmd(2 * ONE, 2 * ONE, -262144, -3));
      cmd_queue.push_back(cast_cmd(62 * ONE, 62 * ONE + 9, 262143, 262143));
      cmd_queue.push_back(cast_cmd(9 * ONE + 65535, 5 * ONE + 1, 1, 0));
      cmd_queue.push_back(cast_cmd(9 * ONE, 5 * ONE, 1, -1));
      cmd_queue.push_back(cast_cmd(30 * ONE, 30 * ONE, 0, 0));
      cmd_queue.push_back(cast_cmd(11 * ONE, 5 * ONE + ONE / 2, -ONE, ONE / 4));
      random_burst(170);
      drain();
      set_rows(12'd4095);
      random_burst(190);
      drain();
      set_rows(12'd1);
      no_idle = 1;
      random_burst(190);
      drain();
      no_idle = 0;
      set_rows(12'd0);
      random_burst(90);
      drain();
      set_rows(gdr_pkg::SCR_W'($urandom_range(4095)));
      random_burst(150);
      drain();
      set_rows(12'd480);
      random_burst(150);
      drain();
      repeat (700) @(posedge clock);
      $display("%0d casts (%0d hit a wall) and %0d cell writes over 6 screen heights,",
               casts, hits, writes);
      $display("%0d results checked", results);
      if (errors == 0 && hit_queue.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
